/* design/matrix3x3_inverse_cramer_macros.svh */
//------------------------------------------------------------------------------
// matrix3x3_inverse_cramer_macros
// assertion macros used by the checker file of the 3x3 inverse block
//------------------------------------------------------------------------------
`ifndef MATRIX3X3_INVERSE_CRAMER_MACROS_SVH
`define MATRIX3X3_INVERSE_CRAMER_MACROS_SVH

// same-cycle implication, off during reset
`define M3I_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define M3I_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/m3i_pkg.sv */
//------------------------------------------------------------------------------
// m3i_pkg
// constants shared by the 3x3 matrix inverse pipeline and its checker
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package m3i_pkg;

    // register stages ahead of the divider
    localparam int unsigned FRONT_STAGES = 8;

    // operand sources of each cofactor: m0*m1 - m2*m3, flat row-major index
    localparam logic [3:0] COF_SRC [9][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd7, 4'd2, 4'd8, 4'd1},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd8, 4'd0, 4'd6, 4'd2},
        '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd6, 4'd1, 4'd7, 4'd0},
        '{4'd0, 4'd4, 4'd1, 4'd3}
    };

endpackage

/* design/matrix3x3_inverse_cramer.sv */
//------------------------------------------------------------------------------
// matrix3x3_inverse_cramer
// 3x3 fixed-point matrix inverse by cofactors over an exact determinant
//------------------------------------------------------------------------------
// Input channel: i_valid / o_stall with the nine entries i_a11 .. i_a33, signed
// with FRAC_BITS fraction bits. Output channel: o_valid / i_stall with the nine
// inverse entries o_b11 .. o_b33, o_det_value, o_singular and o_saturated.
// An item moves on a rising edge where valid is high and stall is low.
// Throughput is one item per cycle while the output is not stalled. The path
// from the accepting edge to o_valid: eight stages of products, cofactors and
// determinant, then a restoring divider of WORD_BITS + 2 stages (an overflow
// check, then one quotient bit per stage for all nine entries at once), then the
// output register. Results are rounded to nearest with ties away from zero and
// saturated; a zero determinant gives zeros with o_singular set.
// Reset is synchronous and clears every stage valid bit; data is not cleared.
// While i_stall holds a valid result the whole pipeline freezes and o_stall
// is raised, so nothing is lost or repeated.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix3x3_inverse_cramer #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [WORD_BITS-1:0] i_a11,
    input  logic signed [WORD_BITS-1:0] i_a12,
    input  logic signed [WORD_BITS-1:0] i_a13,
    input  logic signed [WORD_BITS-1:0] i_a21,
    input  logic signed [WORD_BITS-1:0] i_a22,
    input  logic signed [WORD_BITS-1:0] i_a23,
    input  logic signed [WORD_BITS-1:0] i_a31,
    input  logic signed [WORD_BITS-1:0] i_a32,
    input  logic signed [WORD_BITS-1:0] i_a33,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [WORD_BITS-1:0] o_b11,
    output logic signed [WORD_BITS-1:0] o_b12,
    output logic signed [WORD_BITS-1:0] o_b13,
    output logic signed [WORD_BITS-1:0] o_b21,
    output logic signed [WORD_BITS-1:0] o_b22,
    output logic signed [WORD_BITS-1:0] o_b23,
    output logic signed [WORD_BITS-1:0] o_b31,
    output logic signed [WORD_BITS-1:0] o_b32,
    output logic signed [WORD_BITS-1:0] o_b33,
    output logic signed [WORD_BITS-1:0] o_det_value,
    output logic                        o_singular,
    output logic                        o_saturated
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W;
    localparam int CW = 2 * W + 1;
    localparam int MW = 3 * W;
    localparam int DW = 3 * W + 1;
    localparam int XW = ((MW > 2 * F) ? MW : 2 * F) + 1;
    localparam int RW = ((4 * W + 2) > (2 * W + 2 * F + 2)) ? 4 * W + 2 : 2 * W + 2 * F + 2;
    localparam int QW = W + 1;
    localparam int DS = W + 2;
    localparam int FS = m3i_pkg::FRONT_STAGES;

    localparam logic [XW-1:0] HALF    = XW'(1) << (2 * F - 1);
    localparam logic [QW-1:0] LIM_NEG = QW'(1) << (W - 1);
    localparam logic [QW-1:0] LIM_POS = LIM_NEG - QW'(1);

    logic w_adv;

    // valid bits
    logic [FS-1:0] r_fv;
    logic [DS-1:0] r_dv;
    logic          r_ov;

    // front stages
    logic signed [W-1:0]  r_a    [9];
    logic signed [PW-1:0] r_p1   [9];
    logic signed [PW-1:0] r_p2   [9];
    logic signed [W-1:0]  r_row2 [3];
    logic signed [CW-1:0] r_c3   [9];
    logic signed [W-1:0]  r_row3 [3];
    logic signed [PW:0]   r_lo4  [3];
    logic signed [PW:0]   r_hi4  [3];
    logic [PW-1:0]        r_cm4  [9];
    logic                 r_cn4  [9];
    logic signed [DW-1:0] r_t5   [3];
    logic [PW-1:0]        r_cm5  [9];
    logic                 r_cn5  [9];
    logic signed [DW-1:0] r_det6;
    logic [PW-1:0]        r_cm6  [9];
    logic                 r_cn6  [9];
    logic [MW-1:0]        r_dm7;
    logic                 r_dn7;
    logic                 r_dz7;
    logic [PW-1:0]        r_cm7  [9];
    logic                 r_cn7  [9];
    logic [RW-1:0]        r_n8   [9];
    logic [MW:0]          r_d8;
    logic [XW-1:0]        r_dr8;
    logic                 r_dn8;
    logic                 r_dz8;
    logic                 r_cn8  [9];

    // divider stages
    logic [RW-1:0] r_rem  [DS][9];
    logic [QW-1:0] r_quo  [DS][9];
    logic          r_big  [DS][9];
    logic          r_cn_d [DS][9];
    logic [MW:0]   r_den  [DS];
    logic [XW-1:0] r_dr_d [DS];
    logic          r_dn_d [DS];
    logic          r_dz_d [DS];
    logic [RW-1:0] n_rem  [DS][9];
    logic [QW-1:0] n_quo  [DS][9];
    logic          n_ge   [DS][9];

    // output stage
    logic signed [W-1:0] r_b [9];
    logic signed [W-1:0] r_det;
    logic                r_sing;
    logic                r_sat;
    logic        [W-1:0] n_b [9];
    logic        [W-1:0] n_det;
    logic                n_sat;
    logic        [QW-1:0] v_lim [9];
    logic        [QW-1:0] v_u   [9];
    logic        [QW-1:0] v_un  [9];
    logic                 v_neg [9];
    logic                 v_esat [9];
    logic        [QW-1:0] v_dlim;
    logic        [QW-1:0] v_du;
    logic        [QW-1:0] v_dun;
    logic                 v_dsat;

    assign w_adv   = !(r_ov && i_stall);
    assign o_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
            r_dv <= '0;
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_fv <= {r_fv[FS-2:0], i_valid};
            r_dv <= {r_dv[DS-2:0], r_fv[FS-1]};
            r_ov <= r_dv[DS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a[0] <= i_a11;
            r_a[1] <= i_a12;
            r_a[2] <= i_a13;
            r_a[3] <= i_a21;
            r_a[4] <= i_a22;
            r_a[5] <= i_a23;
            r_a[6] <= i_a31;
            r_a[7] <= i_a32;
            r_a[8] <= i_a33;
            for (int e = 0; e < 9; e++) begin
                r_p1[e] <= r_a[m3i_pkg::COF_SRC[e][0]] * r_a[m3i_pkg::COF_SRC[e][1]];
                r_p2[e] <= r_a[m3i_pkg::COF_SRC[e][2]] * r_a[m3i_pkg::COF_SRC[e][3]];
                r_c3[e] <= CW'(r_p1[e]) - CW'(r_p2[e]);
                r_cm4[e] <= r_c3[e][CW-1] ? PW'(-r_c3[e]) : PW'(r_c3[e]);
                r_cn4[e] <= r_c3[e][CW-1];
                r_cm5[e] <= r_cm4[e];
                r_cn5[e] <= r_cn4[e];
                r_cm6[e] <= r_cm5[e];
                r_cn6[e] <= r_cn5[e];
                r_cm7[e] <= r_cm6[e];
                r_cn7[e] <= r_cn6[e];
                r_n8[e]  <= (RW'(r_cm7[e]) << (2 * F + 1)) + RW'(r_dm7);
                r_cn8[e] <= r_cn7[e];
            end
            for (int j = 0; j < 3; j++) begin
                r_row2[j] <= r_a[j];
                r_row3[j] <= r_row2[j];
                r_lo4[j]  <= r_row3[j] * $signed({1'b0, r_c3[3 * j][W-1:0]});
                r_hi4[j]  <= r_row3[j] * $signed(r_c3[3 * j][CW-1:W]);
                r_t5[j]   <= $signed({r_hi4[j], {W{1'b0}}}) + DW'(r_lo4[j]);
            end
            r_det6 <= r_t5[0] + r_t5[1] + r_t5[2];
            r_dm7  <= r_det6[DW-1] ? MW'(-r_det6) : MW'(r_det6);
            r_dn7  <= r_det6[DW-1];
            r_dz7  <= (r_det6 == '0);
            r_d8   <= {r_dm7, 1'b0};
            r_dr8  <= (XW'(r_dm7) + HALF) >> (2 * F);
            r_dn8  <= r_dn7;
            r_dz8  <= r_dz7;
        end
    end

    // restoring division, overflow check first, then one quotient bit a stage
    always_comb begin
        for (int e = 0; e < 9; e++) begin
            n_ge[0][e]  = r_n8[e] >= (RW'(r_d8) << (W + 1));
            n_rem[0][e] = r_n8[e];
            n_quo[0][e] = '0;
        end
        for (int s = 1; s < DS; s++) begin
            for (int e = 0; e < 9; e++) begin
                n_ge[s][e]  = r_rem[s-1][e] >= (RW'(r_den[s-1]) << (W + 1 - s));
                n_rem[s][e] = n_ge[s][e] ?
                              r_rem[s-1][e] - (RW'(r_den[s-1]) << (W + 1 - s)) :
                              r_rem[s-1][e];
                n_quo[s][e] = {r_quo[s-1][e][QW-2:0], n_ge[s][e]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int e = 0; e < 9; e++) begin
                r_big[0][e]  <= n_ge[0][e];
                r_cn_d[0][e] <= r_cn8[e];
            end
            r_den[0]  <= r_d8;
            r_dr_d[0] <= r_dr8;
            r_dn_d[0] <= r_dn8;
            r_dz_d[0] <= r_dz8;
            for (int s = 1; s < DS; s++) begin
                for (int e = 0; e < 9; e++) begin
                    r_big[s][e]  <= r_big[s-1][e];
                    r_cn_d[s][e] <= r_cn_d[s-1][e];
                end
                r_den[s]  <= r_den[s-1];
                r_dr_d[s] <= r_dr_d[s-1];
                r_dn_d[s] <= r_dn_d[s-1];
                r_dz_d[s] <= r_dz_d[s-1];
            end
            for (int s = 0; s < DS; s++) begin
                for (int e = 0; e < 9; e++) begin
                    r_rem[s][e] <= n_rem[s][e];
                    r_quo[s][e] <= n_quo[s][e];
                end
            end
        end
    end

    // rounding done in the divider; saturate, apply sign, zero when singular
    always_comb begin
        for (int e = 0; e < 9; e++) begin
            v_neg[e]  = r_cn_d[DS-1][e] ^ r_dn_d[DS-1];
            v_lim[e]  = v_neg[e] ? LIM_NEG : LIM_POS;
            v_esat[e] = r_big[DS-1][e] || (r_quo[DS-1][e] > v_lim[e]);
            v_u[e]    = v_esat[e] ? v_lim[e] : r_quo[DS-1][e];
            v_un[e]   = QW'(0) - v_u[e];
            n_b[e]    = r_dz_d[DS-1] ? '0 : (v_neg[e] ? v_un[e][W-1:0] : v_u[e][W-1:0]);
        end
        v_dlim = r_dn_d[DS-1] ? LIM_NEG : LIM_POS;
        v_dsat = r_dr_d[DS-1] > XW'(v_dlim);
        v_du   = v_dsat ? v_dlim : QW'(r_dr_d[DS-1]);
        v_dun  = QW'(0) - v_du;
        n_det  = r_dz_d[DS-1] ? '0 : (r_dn_d[DS-1] ? v_dun[W-1:0] : v_du[W-1:0]);
        n_sat  = v_dsat;
        for (int e = 0; e < 9; e++) begin
            n_sat = n_sat || v_esat[e];
        end
        n_sat = n_sat && !r_dz_d[DS-1];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int e = 0; e < 9; e++) begin
                r_b[e] <= n_b[e];
            end
            r_det  <= n_det;
            r_sing <= r_dz_d[DS-1];
            r_sat  <= n_sat;
        end
    end

    assign o_valid     = r_ov;
    assign o_b11       = r_b[0];
    assign o_b12       = r_b[1];
    assign o_b13       = r_b[2];
    assign o_b21       = r_b[3];
    assign o_b22       = r_b[4];
    assign o_b23       = r_b[5];
    assign o_b31       = r_b[6];
    assign o_b32       = r_b[7];
    assign o_b33       = r_b[8];
    assign o_det_value = r_det;
    assign o_singular  = r_sing;
    assign o_saturated = r_sat;

endmodule

/* design/m3i_checker.sv */
//------------------------------------------------------------------------------
// m3i_checker
// port-level checks of the 3x3 matrix inverse pipeline, bound to the top level
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "matrix3x3_inverse_cramer_macros.svh"

module m3i_checker #(
    parameter int WORD_BITS = 32
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic signed [WORD_BITS-1:0] o_b11,
    input logic signed [WORD_BITS-1:0] o_b12,
    input logic signed [WORD_BITS-1:0] o_b13,
    input logic signed [WORD_BITS-1:0] o_b21,
    input logic signed [WORD_BITS-1:0] o_b22,
    input logic signed [WORD_BITS-1:0] o_b23,
    input logic signed [WORD_BITS-1:0] o_b31,
    input logic signed [WORD_BITS-1:0] o_b32,
    input logic signed [WORD_BITS-1:0] o_b33,
    input logic signed [WORD_BITS-1:0] o_det_value,
    input logic                        o_singular,
    input logic                        o_saturated
);

    logic [10*WORD_BITS+1:0] w_item;
    logic                    w_vals_zero;

    assign w_item = {o_b11, o_b12, o_b13, o_b21, o_b22, o_b23, o_b31, o_b32, o_b33,
                     o_det_value, o_singular, o_saturated};
    assign w_vals_zero = ({o_b11, o_b12, o_b13, o_b21, o_b22, o_b23, o_b31, o_b32, o_b33,
                           o_det_value} == '0);

    // a stalled item holds
    `M3I_ASSERT_NXT(a_hold, o_valid && i_stall, o_valid && $stable(w_item), "stalled item changed")

    // singular item is all zeros and never saturated
    `M3I_ASSERT_IMP(a_singular_zero, o_valid && o_singular, w_vals_zero && !o_saturated, "bad singular")

    // no result can emerge shortly after reset
    `M3I_ASSERT_IMP(a_reset_flush, o_valid, $past(i_rst_n, m3i_pkg::FRONT_STAGES), "early item")

endmodule

bind matrix3x3_inverse_cramer m3i_checker #(.WORD_BITS(WORD_BITS)) u_m3i_checker (.*);
